>>> design/psc_pkg.sv
package psc_pkg;

    localparam int RAW_W     = 24;
    localparam int CAL_W     = 16;
    localparam int DT_W      = 25;
    localparam int Q_W       = 19;
    localparam int OFF_W     = 38;
    localparam int SENS_W    = 38;
    localparam int T2_W      = 17;
    localparam int PRES_W    = 32;
    localparam int TEMP_W    = 19;
    localparam int CFG_IDX_W = 3;

    // Calibration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SENSITIVITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY_TEMP_COEFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEFF      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_TEMPERATURE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE_SLOPE      = 3'd5;

    // Reference temperature (20.00 C) and the distance from it to -15.00 C
    localparam int TEMP_REF = 2000;
    localparam int LOW_BIAS = 3500;

    typedef struct packed {
        logic [CAL_W-1:0] pressure_sensitivity;
        logic [CAL_W-1:0] pressure_offset;
        logic [CAL_W-1:0] sensitivity_temp_coeff;
        logic [CAL_W-1:0] offset_temp_coeff;
        logic [CAL_W-1:0] reference_temperature;
        logic [CAL_W-1:0] temperature_slope;
    } t_cal;

    // First-order result: q is TEMP - 2000 before the second-order fix
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [Q_W-1:0]    q;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
        logic [T2_W-1:0]          t2;
    } t_fo_data;

    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
    } t_so_data;

endpackage

>>> design/psc_cfg_regs.sv
module psc_cfg_regs
    import psc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [CAL_W-1:0]     i_data,
    output t_cal                 o_cal
);

    t_cal r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_we) begin
            case (i_index)
                REG_PRESSURE_SENSITIVITY:   r_cal.pressure_sensitivity   <= i_data;
                REG_PRESSURE_OFFSET:        r_cal.pressure_offset        <= i_data;
                REG_SENSITIVITY_TEMP_COEFF: r_cal.sensitivity_temp_coeff <= i_data;
                REG_OFFSET_TEMP_COEFF:      r_cal.offset_temp_coeff      <= i_data;
                REG_REFERENCE_TEMPERATURE:  r_cal.reference_temperature  <= i_data;
                REG_TEMPERATURE_SLOPE:      r_cal.temperature_slope      <= i_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign o_cal = r_cal;

endmodule

>>> design/psc_first_order.sv
module psc_first_order
    import psc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cal             i_cal,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [RAW_W-1:0] i_raw_pressure,
    input  logic [RAW_W-1:0] i_raw_temperature,
    output logic             o_valid,
    input  logic             i_stall,
    output t_fo_data         o_data
);

    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    // Stage 1: dT
    logic [RAW_W-1:0]       r1_d1;
    logic signed [DT_W-1:0] r1_dt, n_dt;
    // Stage 2: products with dT
    logic [RAW_W-1:0]       r2_d1;
    logic signed [41:0]     r2_mt, r2_mo, r2_ms, n_mt, n_mo, n_ms;
    logic signed [49:0]     n_dtsq;
    logic [47:0]            r2_dtsq;
    // Stage 3: scale and sum
    logic [41:0]            n_mt_b, n_mo_b, n_ms_b;
    logic [49:0]            n_t2x3;
    logic signed [Q_W-1:0]  n_q;
    logic signed [OFF_W-1:0]  n_off;
    logic signed [SENS_W-1:0] n_sens;
    t_fo_data               r3_data;

    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign o_valid = r_v3;
    assign o_data  = r3_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    assign n_dt = $signed({1'b0, i_raw_temperature})
                - $signed({1'b0, i_cal.reference_temperature, 8'd0});

    assign n_mt   = r1_dt * $signed({1'b0, i_cal.temperature_slope});
    assign n_mo   = r1_dt * $signed({1'b0, i_cal.offset_temp_coeff});
    assign n_ms   = r1_dt * $signed({1'b0, i_cal.sensitivity_temp_coeff});
    assign n_dtsq = r1_dt * r1_dt;

    // Round negative quotients toward zero: add 2^k-1 before the shift
    assign n_mt_b = r2_mt + {19'd0, {23{r2_mt[41]}}};
    assign n_mo_b = r2_mo + {37'd0, {5{r2_mo[41]}}};
    assign n_ms_b = r2_ms + {35'd0, {7{r2_ms[41]}}};
    assign n_q    = n_mt_b[41:23];
    assign n_off  = $signed({4'd0, i_cal.pressure_offset, 18'd0})
                  + $signed({n_mo_b[41], n_mo_b[41:5]});
    assign n_sens = $signed({5'd0, i_cal.pressure_sensitivity, 17'd0})
                  + $signed({{3{n_ms_b[41]}}, n_ms_b[41:7]});
    assign n_t2x3 = {2'd0, r2_dtsq} + {1'b0, r2_dtsq, 1'b0};

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_d1 <= i_raw_pressure;
            r1_dt <= n_dt;
        end
        if (en2) begin
            r2_d1   <= r1_d1;
            r2_mt   <= n_mt;
            r2_mo   <= n_mo;
            r2_ms   <= n_ms;
            r2_dtsq <= n_dtsq[47:0];
        end
        if (en3) begin
            r3_data.d1   <= r2_d1;
            r3_data.q    <= n_q;
            r3_data.off  <= n_off;
            r3_data.sens <= n_sens;
            r3_data.t2   <= n_t2x3[49:33];
        end
    end

endmodule

>>> design/psc_second_order.sv
module psc_second_order
    import psc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_fo_data i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_so_data o_data
);

    logic r_v4, r_v5, r_v6;
    logic en4, en5, en6;

    // Stage 4: squares and range flags
    t_fo_data           r4_data;
    logic signed [37:0] n_devsq;
    logic signed [19:0] n_low;
    logic signed [39:0] n_lowsq;
    logic [33:0]        r4_devsq, r4_lowsq;
    logic               r4_cold, r4_vcold;
    // Stage 5: correction terms
    t_fo_data           r5_data;
    logic [35:0]        n_dsq3, n_lsq3;
    logic [36:0]        n_dsq7, n_sens2;
    logic [32:0]        r5_off2;
    logic [36:0]        r5_sens2;
    logic [T2_W-1:0]    r5_t2;
    // Stage 6: apply corrections
    logic signed [19:0] n_temp;
    t_so_data           r6_data;

    assign en6     = !r_v6 || !i_stall;
    assign en5     = !r_v5 || en6;
    assign en4     = !r_v4 || en5;
    assign o_stall = !en4;
    assign o_valid = r_v6;
    assign o_data  = r6_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en4) r_v4 <= i_valid;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    // q = TEMP - 2000, low = TEMP + 1500 = q + 3500
    assign n_devsq = i_data.q * i_data.q;
    assign n_low   = {i_data.q[Q_W-1], i_data.q} + 20'(LOW_BIAS);
    assign n_lowsq = n_low * n_low;

    assign n_dsq3  = {2'd0, r4_devsq} + {1'b0, r4_devsq, 1'b0};
    assign n_dsq7  = {r4_devsq, 3'd0} - {3'd0, r4_devsq};
    assign n_lsq3  = {2'd0, r4_lowsq} + {1'b0, r4_lowsq, 1'b0};
    assign n_sens2 = {3'd0, n_dsq7[36:3]} + (r4_vcold ? {1'b0, n_lsq3} : 37'd0);

    assign n_temp = {r5_data.q[Q_W-1], r5_data.q} + 20'(TEMP_REF) - {3'd0, r5_t2};

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_data  <= i_data;
            r4_devsq <= n_devsq[33:0];
            r4_lowsq <= n_lowsq[33:0];
            r4_cold  <= i_data.q[Q_W-1];
            r4_vcold <= n_low[19];
        end
        if (en5) begin
            r5_data  <= r4_data;
            r5_off2  <= r4_cold ? n_dsq3[35:3] : 33'd0;
            r5_sens2 <= r4_cold ? n_sens2 : 37'd0;
            r5_t2    <= r4_cold ? r4_data.t2 : '0;
        end
        if (en6) begin
            r6_data.d1   <= r5_data.d1;
            r6_data.temp <= n_temp[TEMP_W-1:0];
            r6_data.off  <= r5_data.off - $signed({5'd0, r5_off2});
            r6_data.sens <= r5_data.sens - $signed({1'b0, r5_sens2});
        end
    end

endmodule

>>> design/psc_pressure.sv
module psc_pressure
    import psc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  t_so_data                 i_data,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [PRES_W-1:0] o_pressure,
    output logic signed [TEMP_W-1:0] o_temperature
);

    logic r_v7, r_v8, r_v9, r_v10, r_v11;
    logic en7, en8, en9, en10, en11;

    // Carried along
    logic signed [OFF_W-1:0]  r7_off, r8_off, r9_off;
    logic signed [TEMP_W-1:0] r7_temp, r8_temp, r9_temp, r10_temp, r11_temp;
    // Stage 7: partial products of D1 * SENS
    logic [41:0]        n_pl, r7_pl;
    logic signed [44:0] n_ph, r7_ph;
    // Stage 8: full product
    logic signed [61:0] n_prod, r8_prod;
    // Stage 9: divide by 2^21
    logic [61:0]        n_prod_b;
    logic signed [40:0] r9_a;
    // Stage 10: subtract offset
    logic signed [41:0] r10_b;
    // Stage 11: divide by 2^15
    logic [41:0]        n_b_b;
    logic signed [26:0] n_p;
    logic signed [PRES_W-1:0] r11_pres;

    assign en11    = !r_v11 || !i_stall;
    assign en10    = !r_v10 || en11;
    assign en9     = !r_v9 || en10;
    assign en8     = !r_v8 || en9;
    assign en7     = !r_v7 || en8;
    assign o_stall = !en7;
    assign o_valid = r_v11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
            r_v11 <= 1'b0;
        end else begin
            if (en7)  r_v7  <= i_valid;
            if (en8)  r_v8  <= r_v7;
            if (en9)  r_v9  <= r_v8;
            if (en10) r_v10 <= r_v9;
            if (en11) r_v11 <= r_v10;
        end
    end

    // Split SENS into a signed upper part and an unsigned 18-bit lower part
    assign n_pl = i_data.d1 * i_data.sens[17:0];
    assign n_ph = $signed({1'b0, i_data.d1}) * $signed(i_data.sens[SENS_W-1:18]);

    assign n_prod = $signed({r7_ph[43:0], 18'd0}) + $signed({20'd0, r7_pl});

    // Round toward zero on both scalings
    assign n_prod_b = r8_prod + {41'd0, {21{r8_prod[61]}}};
    assign n_b_b    = r10_b + {27'd0, {15{r10_b[41]}}};
    assign n_p      = n_b_b[41:15];

    always_ff @(posedge i_clk) begin
        if (en7) begin
            r7_pl   <= n_pl;
            r7_ph   <= n_ph;
            r7_off  <= i_data.off;
            r7_temp <= i_data.temp;
        end
        if (en8) begin
            r8_prod <= n_prod;
            r8_off  <= r7_off;
            r8_temp <= r7_temp;
        end
        if (en9) begin
            r9_a    <= n_prod_b[61:21];
            r9_off  <= r8_off;
            r9_temp <= r8_temp;
        end
        if (en10) begin
            r10_b    <= {r9_a[40], r9_a} - {{4{r9_off[OFF_W-1]}}, r9_off};
            r10_temp <= r9_temp;
        end
        if (en11) begin
            r11_pres <= {{(PRES_W-27){n_p[26]}}, n_p};
            r11_temp <= r10_temp;
        end
    end

    assign o_pressure    = r11_pres;
    assign o_temperature = r11_temp;

endmodule

>>> design/pressure_sensor_compensation_top.sv
// Pressure sensor compensation, first- and second-order datasheet scheme.
// Each transaction carries one raw pressure conversion (D1) and one raw
// temperature conversion (D2); each produces exactly one result: pressure in
// hundredths of a millibar and temperature in hundredths of a degree Celsius.
// The six 16-bit calibration words live in registers 0..5 (C1..C6) written
// through the cfg port, which is always ready; writes to index 6 or 7 are
// dropped. Write them only while the block is idle. All registers clear to
// zero at reset and no clearing pass is needed afterward.
// Throughput is one transaction per clock while i_stall is low; the depth is
// set by the multiplier stages (dT products, squares, and the split D1*SENS
// product) plus the round-toward-zero scaling steps.
// Backpressure on i_stall freezes only stages that hold data, so bubbles
// collapse and new inputs keep flowing in while a finished result waits.
// With 24-bit raw inputs and 16-bit calibration words the pressure stays
// within a 27-bit signed range, so the 32-bit output never needs saturation.
module pressure_sensor_compensation_top
    import psc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Sample input
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [RAW_W-1:0]         i_raw_pressure,
    input  logic [RAW_W-1:0]         i_raw_temperature,
    // Result output
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [PRES_W-1:0] o_pressure,
    output logic signed [TEMP_W-1:0] o_temperature,
    // Calibration write port
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CAL_W-1:0]         i_cfg_data
);

    t_cal     cal;
    t_fo_data fo_data;
    t_so_data so_data;
    logic     fo_valid, fo_stall;
    logic     so_valid, so_stall;

    // The register file takes every write, so the port is always ready
    assign o_cfg_ready = 1'b1;

    psc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cal   (cal)
    );

    // Stages 1-3: dT, first-order TEMP, OFF, SENS, and the T2 term
    psc_first_order u_first (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cal             (cal),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .o_valid           (fo_valid),
        .i_stall           (fo_stall),
        .o_data            (fo_data)
    );

    // Stages 4-6: low-temperature corrections
    psc_second_order u_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fo_valid),
        .o_stall (fo_stall),
        .i_data  (fo_data),
        .o_valid (so_valid),
        .i_stall (so_stall),
        .o_data  (so_data)
    );

    // Stages 7-11: P = (D1*SENS/2^21 - OFF)/2^15, then the output register
    psc_pressure u_pressure (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (so_valid),
        .o_stall       (so_stall),
        .i_data        (so_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pressure    (o_pressure),
        .o_temperature (o_temperature)
    );

endmodule

>>> dv/psc_result_checker.sv
module psc_result_checker
    import psc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic [RAW_W-1:0]         i_raw_pressure,
    input  logic [RAW_W-1:0]         i_raw_temperature,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic signed [PRES_W-1:0] i_pressure,
    input  logic signed [TEMP_W-1:0] i_temperature,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CAL_W-1:0]         i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [PRES_W-1:0] pressure;
        logic signed [TEMP_W-1:0] temperature;
    } t_reading;

    t_cal     cal_shadow;
    t_reading expected_readings[$];

    // Quotient by 2^k, truncated toward zero
    function automatic longint scale_down(longint v, int k);
        return v / (longint'(1) << k);
    endfunction

    function automatic t_reading compensate_sample(logic [RAW_W-1:0] raw_p,
                                                   logic [RAW_W-1:0] raw_t,
                                                   t_cal c);
        longint   d1, d2, dt, temp, off, sens, t2, off2, sens2, dev, cold, p;
        t_reading r;
        d1    = raw_p;
        d2    = raw_t;
        dt    = d2 - longint'(c.reference_temperature) * 256;
        temp  = TEMP_REF + scale_down(dt * longint'(c.temperature_slope), 23);
        off   = longint'(c.pressure_offset) * 262144
              + scale_down(longint'(c.offset_temp_coeff) * dt, 5);
        sens  = longint'(c.pressure_sensitivity) * 131072
              + scale_down(longint'(c.sensitivity_temp_coeff) * dt, 7);
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        // Second-order fix below 20.00 C, extra sensitivity term below -15.00 C
        if (temp < TEMP_REF) begin
            dev   = temp - TEMP_REF;
            t2    = scale_down(3 * dt * dt, 33);
            off2  = scale_down(3 * dev * dev, 3);
            sens2 = scale_down(7 * dev * dev, 3);
            if (temp < TEMP_REF - LOW_BIAS) begin
                cold  = temp - (TEMP_REF - LOW_BIAS);
                sens2 = sens2 + 3 * cold * cold;
            end
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
        p    = scale_down(scale_down(d1 * sens, 21) - off, 15);
        if (p > longint'(32'sh7fff_ffff))
            p = longint'(32'sh7fff_ffff);
        if (p < -longint'(64'sh8000_0000))
            p = -longint'(64'sh8000_0000);
        r.pressure    = p[PRES_W-1:0];
        r.temperature = temp[TEMP_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_reading want;
        if (!i_rst_n) begin
            cal_shadow <= '0;
            expected_readings.delete();
            o_pending  <= 0;
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_PRESSURE_SENSITIVITY:   cal_shadow.pressure_sensitivity   <= i_cfg_data;
                    REG_PRESSURE_OFFSET:        cal_shadow.pressure_offset        <= i_cfg_data;
                    REG_SENSITIVITY_TEMP_COEFF: cal_shadow.sensitivity_temp_coeff <= i_cfg_data;
                    REG_OFFSET_TEMP_COEFF:      cal_shadow.offset_temp_coeff      <= i_cfg_data;
                    REG_REFERENCE_TEMPERATURE:  cal_shadow.reference_temperature  <= i_cfg_data;
                    REG_TEMPERATURE_SLOPE:      cal_shadow.temperature_slope      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch("unexpected result, pressure", i_pressure, 0);
                end else begin
                    want = expected_readings.pop_front();
                    if (i_pressure !== want.pressure)
                        report_mismatch("pressure", i_pressure, want.pressure);
                    if (i_temperature !== want.temperature)
                        report_mismatch("temperature", i_temperature, want.temperature);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_readings.push_back(
                    compensate_sample(i_raw_pressure, i_raw_temperature, cal_shadow));
            o_pending <= expected_readings.size();
        end
    end

endmodule

>>> dv/pressure_sensor_compensation_top_tb.sv
module pressure_sensor_compensation_top_tb
    import psc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Write indexes past the last calibration word; the block must drop them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int                   RAW_MAX      = (1 << RAW_W) - 1;
    localparam int                   CAL_MAX      = (1 << CAL_W) - 1;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [RAW_W-1:0]         i_raw_pressure;
    logic [RAW_W-1:0]         i_raw_temperature;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [PRES_W-1:0] o_pressure;
    logic signed [TEMP_W-1:0] o_temperature;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CAL_W-1:0]         i_cfg_data;

    int   fail_count;
    int   pending_readings;
    int   idle_pct;     // chance per cycle that either side idles
    t_cal cal_now;      // calibration as last written, used to aim the stimulus

    always #10 i_clk = ~i_clk;

    pressure_sensor_compensation_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_pressure        (o_pressure),
        .o_temperature     (o_temperature),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    psc_result_checker checker_inst (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_pressure        (o_pressure),
        .i_temperature     (o_temperature),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending_readings)
    );

    // Receiver backpressure: stall at random on the falling edge, never in reset
    always @(negedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(0, 99) < idle_pct);
    end

    // Clamp a computed raw reading into the 24-bit conversion range
    function automatic logic [RAW_W-1:0] clamp_raw(longint v);
        if (v < 0)
            return '0;
        if (v > RAW_MAX)
            return RAW_W'(RAW_MAX);
        return RAW_W'(v);
    endfunction

    // Issue one calibration write; leave valid high, the caller drops it.
    // Enter and leave on a falling edge.
    task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        case (idx)
            REG_PRESSURE_SENSITIVITY:   cal_now.pressure_sensitivity   = data;
            REG_PRESSURE_OFFSET:        cal_now.pressure_offset        = data;
            REG_SENSITIVITY_TEMP_COEFF: cal_now.sensitivity_temp_coeff = data;
            REG_OFFSET_TEMP_COEFF:      cal_now.offset_temp_coeff      = data;
            REG_REFERENCE_TEMPERATURE:  cal_now.reference_temperature  = data;
            REG_TEMPERATURE_SLOPE:      cal_now.temperature_slope      = data;
            default: ;
        endcase
    endtask

    task automatic load_calibration(t_cal c);
        write_cal(REG_PRESSURE_SENSITIVITY,   c.pressure_sensitivity);
        write_cal(REG_PRESSURE_OFFSET,        c.pressure_offset);
        write_cal(REG_SENSITIVITY_TEMP_COEFF, c.sensitivity_temp_coeff);
        write_cal(REG_OFFSET_TEMP_COEFF,      c.offset_temp_coeff);
        write_cal(REG_REFERENCE_TEMPERATURE,  c.reference_temperature);
        write_cal(REG_TEMPERATURE_SLOPE,      c.temperature_slope);
        i_cfg_valid = 1'b0;
    endtask

    // Offer one sample transaction after a random idle gap and hold it until
    // the block takes it. Valid stays high afterward so that back-to-back
    // transactions need no toggle; drain_pipeline drops it.
    task automatic send_sample(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid           = 1'b1;
        i_raw_pressure    = d1;
        i_raw_temperature = d2;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic drain_pipeline();
        i_valid = 1'b0;
        while (pending_readings != 0)
            @(negedge i_clk);
    endtask

    // Random sample aimed at the current calibration: half anywhere, the rest
    // near the reference reading or on the cold side of it.
    task automatic send_random_sample();
        logic [RAW_W-1:0] d1;
        longint           ref_d2;
        longint           d2;
        ref_d2 = longint'(cal_now.reference_temperature) * 256;
        case ($urandom_range(0, 7))
            0:       d1 = '0;
            1:       d1 = RAW_W'(RAW_MAX);
            default: d1 = RAW_W'($urandom_range(0, RAW_MAX));
        endcase
        case ($urandom_range(0, 3))
            0, 1:    d2 = longint'($urandom_range(0, RAW_MAX));
            2:       d2 = ref_d2 + longint'($urandom_range(0, 131072)) - 65536;
            default: d2 = ref_d2 - longint'($urandom_range(0, int'(ref_d2)));
        endcase
        send_sample(d1, clamp_raw(d2));
    endtask

    task automatic run_random_phase(t_cal c, int count, int idle);
        load_calibration(c);
        idle_pct = idle;
        repeat (count) send_random_sample();
        drain_pipeline();
    endtask

    function automatic t_cal random_cal();
        t_cal c;
        c.pressure_sensitivity   = CAL_W'($urandom_range(0, CAL_MAX));
        c.pressure_offset        = CAL_W'($urandom_range(0, CAL_MAX));
        c.sensitivity_temp_coeff = CAL_W'($urandom_range(0, CAL_MAX));
        c.offset_temp_coeff      = CAL_W'($urandom_range(0, CAL_MAX));
        c.reference_temperature  = CAL_W'($urandom_range(0, CAL_MAX));
        c.temperature_slope      = CAL_W'($urandom_range(0, CAL_MAX));
        return c;
    endfunction

    // Run time limit: well above the slowest correct run
    initial begin
        #2_000_000;
        $display("pressure_sensor_compensation_top regression: fail");
        $finish;
    end

    initial begin : stimulus
        t_cal   typical, cold_cal;
        longint ref_d2, step_2000, step_cold;
        longint offsets[$];

        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_raw_pressure    = '0;
        i_raw_temperature = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        cal_now           = '0;
        idle_pct          = 36;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset calibration is all zero: a handful of transactions against it
        send_sample('0, '0);
        send_sample(RAW_W'(RAW_MAX), RAW_W'(RAW_MAX));
        repeat (3) send_random_sample();
        drain_pipeline();

        // Datasheet-like calibration for the directed part
        typical.pressure_sensitivity   = 16'd46372;
        typical.pressure_offset        = 16'd43981;
        typical.sensitivity_temp_coeff = 16'd29059;
        typical.offset_temp_coeff      = 16'd27842;
        typical.reference_temperature  = 16'd31553;
        typical.temperature_slope      = 16'd28165;
        load_calibration(typical);

        // Writes past the last register must leave the calibration alone
        write_cal(REG_SPARE_LO, CAL_W'($urandom_range(0, CAL_MAX)));
        write_cal(REG_SPARE_HI, CAL_W'($urandom_range(0, CAL_MAX)));
        i_cfg_valid = 1'b0;

        // Field extremes, then temperature sweeps across the 20.00 C and
        // -15.00 C thresholds. A step is the D2 span of one hundredth.
        ref_d2    = longint'(typical.reference_temperature) * 256;
        step_2000 = (longint'(1) << 23) / typical.temperature_slope;
        step_cold = (longint'(LOW_BIAS) << 23) / typical.temperature_slope;
        send_sample('0, clamp_raw(ref_d2));
        send_sample(RAW_W'(RAW_MAX), clamp_raw(ref_d2));
        send_sample(RAW_W'(RAW_MAX), '0);
        send_sample('0, '0);
        send_sample(RAW_W'(RAW_MAX), RAW_W'(RAW_MAX));
        send_sample('0, RAW_W'(RAW_MAX));
        offsets = '{0, -1, 1, -step_2000, -step_2000 - 1, -step_2000 + 1,
                    -2 * step_2000 - 1};
        foreach (offsets[k])
            send_sample(RAW_W'($urandom_range(0, RAW_MAX)), clamp_raw(ref_d2 + offsets[k]));
        offsets = '{-step_cold, -step_cold - 1, -step_cold + 1, -step_cold - 2,
                    -step_cold - step_2000, -step_cold - step_2000 - 1};
        foreach (offsets[k])
            send_sample(RAW_W'($urandom_range(0, RAW_MAX)), clamp_raw(ref_d2 + offsets[k]));
        drain_pipeline();

        // Random phases across calibration settings, extremes included
        run_random_phase(typical, 100, 36);
        run_random_phase('1, 100, 36);
        run_random_phase('0, 60, 36);
        // Long stretch with no idling on either side
        run_random_phase(random_cal(), 100, 0);
        cold_cal = random_cal();
        cold_cal.reference_temperature = CAL_W'($urandom_range(49152, CAL_MAX));
        cold_cal.temperature_slope     = CAL_W'($urandom_range(49152, CAL_MAX));
        run_random_phase(cold_cal, 100, 36);

        // Let any stray result surface before the verdict
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending_readings == 0) begin
            $display("pressure_sensor_compensation_top regression: pass");
        end else begin
            $display("pressure_sensor_compensation_top regression: fail");
        end
        $finish;
    end

endmodule
